// File: sv/tcw_pkg.sv
// Package for the text console writer.
// Holds the operation codes, control byte codes, sequencer states and the print control word.
// No dependencies.
package tcw_pkg;

    typedef enum logic [1:0] {
        OP_PRINT = 2'd0,
        OP_CLEAR = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    localparam logic [7:0] CH_BS  = 8'h08;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_SCROLL,
        ST_CLEAR,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic wr_char;
        logic wr_color;
        logic scroll;
    } t_print_ctl;

endpackage

// File: sv/text_console_writer.sv
// Top level of the text console writer: sequencer, sweep counter and result register.
// Depends on tcw_pkg, tcw_cell_mem and tcw_cursor.
//
// Input channel i_valid/o_ready carries one word: operation, char_code, colour, cell_index.
// Output channel o_valid/i_ready returns one word per input word: cursor column, row and
// linear position, the scroll flag and, for a read, the cell's character and colour.
// A print without scroll, a read or a no-op (OP_NONE) goes from ST_IDLE to ST_EMIT, which
// loads its result once the output register is free; only then is the next word accepted.
// A print that scrolls and a clear sweep the whole cell store, one cell per cycle, through
// the single write port of the memory; the result loads in ST_EMIT after the sweep, and no
// new word is accepted before that.
// After reset the store is zeroed by the same sweep, with o_ready low; the cursor is homed
// at once.
// The result sits in an output register: a new word is accepted and worked on while the
// previous result waits, and the sequencer holds the new result until the receiver takes
// the old one. A stalled receiver never loses or repeats a result.
module text_console_writer #(
    parameter int COLUMNS   = 80,
    parameter int ROWS      = 25,
    parameter int TAB_WIDTH = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_operation,
    input  logic [7:0]  i_char_code,
    input  logic [7:0]  i_color,
    input  logic [10:0] i_cell_index,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [6:0]  o_cursor_col,
    output logic [4:0]  o_cursor_row,
    output logic [10:0] o_cursor_pos,
    output logic        o_scrolled,
    output logic [7:0]  o_cell_char,
    output logic [7:0]  o_cell_color
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(COLUMNS);
    localparam int RW    = $clog2(ROWS);
    localparam int COPY  = COLUMNS * (ROWS - 2);

    tcw_pkg::t_state r_state, n_state;
    tcw_pkg::t_op    op;

    logic [AW-1:0] r_sweep;
    logic          sweep_last;
    logic          copy_phase;
    logic          accept;
    logic          emit_load;

    logic          r_mv_valid;
    logic [AW-1:0] r_mv_addr;
    logic          r_mv_zero;
    logic          r_scrolled;
    logic          r_read_hit;

    logic          r_out_valid;
    logic [6:0]    r_out_col;
    logic [4:0]    r_out_row;
    logic [10:0]   r_out_pos;
    logic          r_out_scrolled;
    logic [7:0]    r_out_char;
    logic [7:0]    r_out_color;

    logic          we_char, we_color, re;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [7:0]    wr_char, wr_color;
    logic [7:0]    rd_char, rd_color;

    logic                cur_step, cur_home;
    logic [CW-1:0]       cur_col;
    logic [RW-1:0]       cur_row;
    logic [AW-1:0]       cur_base;
    logic [AW-1:0]       cur_wr_addr;
    tcw_pkg::t_print_ctl cur_ctl;

    assign op         = tcw_pkg::t_op'(i_operation);
    assign accept     = i_valid && o_ready;
    assign sweep_last = (r_sweep == AW'(CELLS - 1));
    assign copy_phase = (32'(r_sweep) < 32'(COPY));
    assign emit_load  = (r_state == tcw_pkg::ST_EMIT) && (!r_out_valid || i_ready);

    tcw_cell_mem #(
        .DEPTH (CELLS)
    ) u_cell_mem (
        .i_clk      (i_clk),
        .i_we_char  (we_char),
        .i_we_color (we_color),
        .i_wr_addr  (wr_addr),
        .i_wr_char  (wr_char),
        .i_wr_color (wr_color),
        .i_re       (re),
        .i_rd_addr  (rd_addr),
        .o_rd_char  (rd_char),
        .o_rd_color (rd_color)
    );

    tcw_cursor #(
        .COLUMNS   (COLUMNS),
        .ROWS      (ROWS),
        .TAB_WIDTH (TAB_WIDTH)
    ) u_cursor (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (cur_step),
        .i_home      (cur_home),
        .i_char_code (i_char_code),
        .o_col       (cur_col),
        .o_row       (cur_row),
        .o_base      (cur_base),
        .o_wr_addr   (cur_wr_addr),
        .o_ctl       (cur_ctl)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tcw_pkg::ST_INIT: begin
                if (sweep_last) begin
                    n_state = tcw_pkg::ST_IDLE;
                end
            end
            tcw_pkg::ST_IDLE: begin
                if (accept) begin
                    unique case (op)
                        tcw_pkg::OP_PRINT: begin
                            n_state = cur_ctl.scroll ? tcw_pkg::ST_SCROLL : tcw_pkg::ST_EMIT;
                        end
                        tcw_pkg::OP_CLEAR: n_state = tcw_pkg::ST_CLEAR;
                        tcw_pkg::OP_READ:  n_state = tcw_pkg::ST_EMIT;
                        tcw_pkg::OP_NONE:  n_state = tcw_pkg::ST_EMIT;
                    endcase
                end
            end
            tcw_pkg::ST_SCROLL, tcw_pkg::ST_CLEAR: begin
                if (sweep_last) begin
                    n_state = tcw_pkg::ST_EMIT;
                end
            end
            tcw_pkg::ST_EMIT: begin
                if (emit_load) begin
                    n_state = tcw_pkg::ST_IDLE;
                end
            end
            default: n_state = tcw_pkg::ST_INIT;
        endcase
    end

    always_comb begin
        o_ready  = (r_state == tcw_pkg::ST_IDLE);
        cur_step = accept && (op == tcw_pkg::OP_PRINT);
        cur_home = accept && (op == tcw_pkg::OP_CLEAR);

        priority if (r_mv_valid) begin
            we_char  = 1'b1;
            we_color = 1'b1;
            wr_addr  = r_mv_addr;
            wr_char  = r_mv_zero ? '0 : rd_char;
            wr_color = r_mv_zero ? '0 : rd_color;
        end else if (r_state == tcw_pkg::ST_INIT || r_state == tcw_pkg::ST_CLEAR) begin
            we_char  = 1'b1;
            we_color = 1'b1;
            wr_addr  = r_sweep;
            wr_char  = '0;
            wr_color = '0;
        end else if (cur_step) begin
            we_char  = cur_ctl.wr_char;
            we_color = cur_ctl.wr_color;
            wr_addr  = cur_wr_addr;
            wr_char  = cur_ctl.wr_color ? i_char_code : '0;
            wr_color = i_color;
        end else begin
            we_char  = 1'b0;
            we_color = 1'b0;
            wr_addr  = '0;
            wr_char  = '0;
            wr_color = '0;
        end

        priority if (accept && op == tcw_pkg::OP_READ) begin
            re      = 1'b1;
            rd_addr = AW'(i_cell_index);
        end else if (r_state == tcw_pkg::ST_SCROLL && copy_phase) begin
            re      = 1'b1;
            rd_addr = r_sweep + AW'(COLUMNS);
        end else begin
            re      = 1'b0;
            rd_addr = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tcw_pkg::ST_INIT;
            r_sweep     <= '0;
            r_mv_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_scrolled  <= 1'b0;
            r_read_hit  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == tcw_pkg::ST_INIT || r_state == tcw_pkg::ST_CLEAR ||
                r_state == tcw_pkg::ST_SCROLL) begin
                r_sweep <= sweep_last ? '0 : r_sweep + AW'(1);
            end
            r_mv_valid <= (r_state == tcw_pkg::ST_SCROLL);
            if (accept) begin
                r_scrolled <= (op == tcw_pkg::OP_PRINT) && cur_ctl.scroll;
                r_read_hit <= (op == tcw_pkg::OP_READ) && (32'(i_cell_index) < 32'(CELLS));
            end
            if (emit_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mv_addr <= r_sweep;
        r_mv_zero <= !copy_phase;
        if (emit_load) begin
            r_out_col      <= 7'(cur_col);
            r_out_row      <= 5'(cur_row);
            r_out_pos      <= 11'(cur_base + AW'(cur_col));
            r_out_scrolled <= r_scrolled;
            r_out_char     <= r_read_hit ? rd_char : '0;
            r_out_color    <= r_read_hit ? rd_color : '0;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_cursor_col = r_out_col;
    assign o_cursor_row = r_out_row;
    assign o_cursor_pos = r_out_pos;
    assign o_scrolled   = r_out_scrolled;
    assign o_cell_char  = r_out_char;
    assign o_cell_color = r_out_color;

endmodule

// File: sv/tcw_cell_mem.sv
// Cell store: character and colour byte arrays sharing one write and one read address.
// Synchronous write, registered read. No package use.
module tcw_cell_mem #(
    parameter int DEPTH = 2000,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we_char,
    input  logic          i_we_color,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [7:0]    i_wr_char,
    input  logic [7:0]    i_wr_color,
    input  logic          i_re,
    input  logic [AW-1:0] i_rd_addr,
    output logic [7:0]    o_rd_char,
    output logic [7:0]    o_rd_color
);

    logic [7:0] r_char_mem  [DEPTH];
    logic [7:0] r_color_mem [DEPTH];
    logic [7:0] r_rd_char;
    logic [7:0] r_rd_color;

    always_ff @(posedge i_clk) begin
        if (i_we_char) begin
            r_char_mem[i_wr_addr] <= i_wr_char;
        end
        if (i_we_color) begin
            r_color_mem[i_wr_addr] <= i_wr_color;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rd_char  <= r_char_mem[i_rd_addr];
            r_rd_color <= r_color_mem[i_rd_addr];
        end
    end

    assign o_rd_char  = r_rd_char;
    assign o_rd_color = r_rd_color;

endmodule

// File: sv/tcw_cursor.sv
// Cursor registers and the print decode: control bytes, column wrap, row advance and scroll request.
// Uses tcw_pkg for the control byte codes and the print control word.
module tcw_cursor #(
    parameter int COLUMNS   = 80,
    parameter int ROWS      = 25,
    parameter int TAB_WIDTH = 8,
    localparam int CELLS = COLUMNS * ROWS,
    localparam int CW    = $clog2(COLUMNS),
    localparam int RW    = $clog2(ROWS),
    localparam int BW    = $clog2(CELLS)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  logic                i_home,
    input  logic [7:0]          i_char_code,
    output logic [CW-1:0]       o_col,
    output logic [RW-1:0]       o_row,
    output logic [BW-1:0]       o_base,
    output logic [BW-1:0]       o_wr_addr,
    output tcw_pkg::t_print_ctl o_ctl
);

    localparam int XW = $clog2(COLUMNS + TAB_WIDTH);
    localparam int PW = $clog2(TAB_WIDTH);

    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;
    logic [BW-1:0] r_base, n_base;
    logic [PW-1:0] r_phase, n_phase;

    logic [XW-1:0]       col_x;
    logic [RW:0]         row_x;
    logic                line_inc;
    logic [BW-1:0]       wr_addr;
    tcw_pkg::t_print_ctl ctl;

    always_comb begin
        col_x    = XW'(r_col);
        n_phase  = r_phase;
        line_inc = 1'b0;
        ctl      = '0;
        wr_addr  = r_base + BW'(r_col);
        unique case (i_char_code)
            tcw_pkg::CH_BS: begin
                if (r_col != '0) begin
                    col_x       = XW'(r_col) - XW'(1);
                    n_phase     = (r_phase == '0) ? PW'(TAB_WIDTH - 1) : r_phase - PW'(1);
                    wr_addr     = r_base + BW'(r_col) - BW'(1);
                    ctl.wr_char = 1'b1;
                end
            end
            tcw_pkg::CH_TAB: begin
                col_x   = XW'(r_col) + XW'(TAB_WIDTH) - XW'(r_phase);
                n_phase = '0;
            end
            tcw_pkg::CH_CR: begin
                col_x   = '0;
                n_phase = '0;
            end
            tcw_pkg::CH_LF: begin
                col_x    = '0;
                n_phase  = '0;
                line_inc = 1'b1;
            end
            default: begin
                ctl.wr_char  = 1'b1;
                ctl.wr_color = 1'b1;
                col_x        = XW'(r_col) + XW'(1);
                n_phase      = (r_phase == PW'(TAB_WIDTH - 1)) ? '0 : r_phase + PW'(1);
            end
        endcase
        if (col_x >= XW'(COLUMNS)) begin
            col_x    = '0;
            n_phase  = '0;
            line_inc = 1'b1;
        end
        row_x      = {1'b0, r_row} + (RW + 1)'(line_inc);
        ctl.scroll = (row_x >= (RW + 1)'(ROWS - 1));
        n_col      = CW'(col_x);
        if (ctl.scroll) begin
            n_row  = r_row;
            n_base = r_base;
        end else begin
            n_row  = RW'(row_x);
            n_base = line_inc ? r_base + BW'(COLUMNS) : r_base;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_home) begin
            r_col   <= '0;
            r_row   <= '0;
            r_base  <= '0;
            r_phase <= '0;
        end else if (i_step) begin
            r_col   <= n_col;
            r_row   <= n_row;
            r_base  <= n_base;
            r_phase <= n_phase;
        end
    end

    assign o_col     = r_col;
    assign o_row     = r_row;
    assign o_base    = r_base;
    assign o_wr_addr = wr_addr;
    assign o_ctl     = ctl;

endmodule

// File: sv/tcw_checker.sv
// Port-level checker for the text console writer, with its bind to the top level.
// Depends only on the ports and parameters of text_console_writer.
module tcw_checker #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [6:0]  o_cursor_col,
    input logic [4:0]  o_cursor_row,
    input logic [10:0] o_cursor_pos,
    input logic        o_scrolled,
    input logic [7:0]  o_cell_char,
    input logic [7:0]  o_cell_color
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_cursor_pos) && $stable(o_scrolled)
            && $stable(o_cell_char) && $stable(o_cell_color))
        else $error("result word changed while stalled");

    a_col_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> 32'(o_cursor_col) < COLUMNS)
        else $error("cursor column beyond last column");

    a_scroll_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_scrolled |-> o_cursor_row == 5'(ROWS - 2))
        else $error("scroll left cursor off the second last row");

    a_accept_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("second word accepted straight after the first");

endmodule

bind text_console_writer tcw_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tcw_checker (.*);

// File: tb/tb_top.sv
// Self-checking bench for text_console_writer: directed then random console traffic.
// Keeps its own screen copy and cursor to predict each result word; depends on tcw_pkg.
`timescale 1ns / 100ps

module tb_top;

    localparam int COLUMNS   = 80;
    localparam int ROWS      = 25;
    localparam int TAB_WIDTH = 8;
    localparam int CELLS     = COLUMNS * ROWS;

    typedef struct packed {
        tcw_pkg::t_op op;
        logic [7:0]   ch;
        logic [7:0]   attr;
        logic [10:0]  idx;
    } t_console_cmd;

    typedef struct packed {
        logic [6:0]  col;
        logic [4:0]  row;
        logic [10:0] pos;
        logic        scrolled;
        logic [7:0]  cell_char;
        logic [7:0]  cell_color;
    } t_console_view;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_operation = 2'd0;
    logic [7:0]  i_char_code = 8'd0;
    logic [7:0]  i_color = 8'd0;
    logic [10:0] i_cell_index = 11'd0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [6:0]  o_cursor_col;
    logic [4:0]  o_cursor_row;
    logic [10:0] o_cursor_pos;
    logic        o_scrolled;
    logic [7:0]  o_cell_char;
    logic [7:0]  o_cell_color;

    t_console_cmd  cmd_backlog[$];
    t_console_view expected_views[$];
    t_console_cmd  cmd_on_bus;

    logic [15:0] screen [CELLS];
    int          cur_col = 0;
    int          cur_row = 0;

    int total_cmds = 1;
    int cmds_sent = 0;
    int views_seen = 0;
    int errors = 0;

    int gap_pct[4]   = '{0, 50, 0, 18};
    int stall_pct[4] = '{0, 0, 50, 18};

    text_console_writer #(
        .COLUMNS  (COLUMNS),
        .ROWS     (ROWS),
        .TAB_WIDTH(TAB_WIDTH)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_operation (i_operation),
        .i_char_code (i_char_code),
        .i_color     (i_color),
        .i_cell_index(i_cell_index),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_cursor_col(o_cursor_col),
        .o_cursor_row(o_cursor_row),
        .o_cursor_pos(o_cursor_pos),
        .o_scrolled  (o_scrolled),
        .o_cell_char (o_cell_char),
        .o_cell_color(o_cell_color)
    );

    always #5 i_clk = ~i_clk;

    function automatic int phase_of(int done);
        int p;
        p = done * 4 / total_cmds;
        return (p > 3) ? 3 : p;
    endfunction

    function automatic t_console_view console_apply(t_console_cmd c);
        t_console_view v;
        int k;
        v = '0;
        case (c.op)
            tcw_pkg::OP_PRINT: begin
                case (c.ch)
                    tcw_pkg::CH_BS: begin
                        if (cur_col > 0) begin
                            cur_col--;
                            screen[cur_row * COLUMNS + cur_col][7:0] = 8'h00;
                        end
                    end
                    tcw_pkg::CH_TAB: cur_col = cur_col + TAB_WIDTH - (cur_col % TAB_WIDTH);
                    tcw_pkg::CH_CR:  cur_col = 0;
                    tcw_pkg::CH_LF: begin
                        cur_col = 0;
                        cur_row++;
                    end
                    default: begin
                        screen[cur_row * COLUMNS + cur_col] = {c.attr, c.ch};
                        cur_col++;
                    end
                endcase
                if (cur_col >= COLUMNS) begin
                    cur_col = 0;
                    cur_row++;
                end
                // shift every row up, blank the two bottom rows
                while (cur_row >= ROWS - 1) begin
                    for (k = 0; k < CELLS - COLUMNS; k++) screen[k] = screen[k + COLUMNS];
                    for (k = (ROWS - 2) * COLUMNS; k < CELLS; k++) screen[k] = 16'h0000;
                    if (cur_row > 0) cur_row--;
                    else cur_col = 0;
                    v.scrolled = 1'b1;
                end
            end
            tcw_pkg::OP_CLEAR: begin
                for (k = 0; k < CELLS; k++) screen[k] = 16'h0000;
                cur_col = 0;
                cur_row = 0;
            end
            tcw_pkg::OP_READ: begin
                if (c.idx < CELLS) begin
                    v.cell_char  = screen[c.idx][7:0];
                    v.cell_color = screen[c.idx][15:8];
                end
            end
            default: ;
        endcase
        v.col = cur_col[6:0];
        v.row = cur_row[4:0];
        v.pos = 11'(cur_row * COLUMNS + cur_col);
        return v;
    endfunction

    task automatic queue_cmd(tcw_pkg::t_op op, int ch, int attr, int idx);
        t_console_cmd c;
        c.op   = op;
        c.ch   = 8'(ch);
        c.attr = 8'(attr);
        c.idx  = 11'(idx);
        cmd_backlog.push_back(c);
    endtask

    task automatic check_field(string fname, int want, int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
            errors++;
        end
    endtask

    // driver: hold the word until accepted, predict on acceptance
    always @(posedge i_clk) begin
        bit load;
        load = 1'b0;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                expected_views.push_back(console_apply(cmd_on_bus));
                cmds_sent++;
                load = 1'b1;
            end else if (!i_valid) begin
                load = 1'b1;
            end
            if (load) begin
                if (cmd_backlog.size() != 0 &&
                    $urandom_range(99) >= gap_pct[phase_of(cmds_sent)]) begin
                    cmd_on_bus = cmd_backlog.pop_front();
                    i_valid      <= 1'b1;
                    i_operation  <= cmd_on_bus.op;
                    i_char_code  <= cmd_on_bus.ch;
                    i_color      <= cmd_on_bus.attr;
                    i_cell_index <= cmd_on_bus.idx;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each accepted result word with the oldest prediction
    always @(posedge i_clk) begin
        t_console_view want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                views_seen++;
                if (expected_views.size() == 0) begin
                    $display("%0t: result word with nothing expected, col %0d row %0d",
                             $time, o_cursor_col, o_cursor_row);
                    errors++;
                end else begin
                    want = expected_views.pop_front();
                    check_field("cursor_col", want.col, o_cursor_col);
                    check_field("cursor_row", want.row, o_cursor_row);
                    check_field("cursor_pos", want.pos, o_cursor_pos);
                    check_field("scrolled", want.scrolled, o_scrolled);
                    check_field("cell_char", want.cell_char, o_cell_char);
                    check_field("cell_color", want.cell_color, o_cell_color);
                end
            end
            i_ready <= ($urandom_range(99) >= stall_pct[phase_of(views_seen)]);
        end
    end

    initial begin
        #40ms;
        $display("status: fail");
        $finish;
    end

    initial begin
        int sel, n, k, pick;
        for (k = 0; k < CELLS; k++) screen[k] = 16'h0000;

        queue_cmd(tcw_pkg::OP_READ, 0, 0, 0);
        queue_cmd(tcw_pkg::OP_PRINT, 8'h41, 8'hFF, 0);
        queue_cmd(tcw_pkg::OP_PRINT, 8'h00, 8'h00, 11'h7FF);
        queue_cmd(tcw_pkg::OP_PRINT, 8'hFF, 8'hA5, 0);
        queue_cmd(tcw_pkg::OP_PRINT, tcw_pkg::CH_BS, 8'hFF, 0);
        queue_cmd(tcw_pkg::OP_READ, 0, 0, 2);
        queue_cmd(tcw_pkg::OP_PRINT, tcw_pkg::CH_CR, 0, 0);
        queue_cmd(tcw_pkg::OP_PRINT, tcw_pkg::CH_BS, 0, 0);
        queue_cmd(tcw_pkg::OP_PRINT, tcw_pkg::CH_TAB, 0, 0);
        queue_cmd(tcw_pkg::OP_PRINT, tcw_pkg::CH_TAB, 0, 0);
        queue_cmd(tcw_pkg::OP_PRINT, tcw_pkg::CH_LF, 8'h77, 0);
        queue_cmd(tcw_pkg::OP_READ, 0, 0, CELLS - 1);
        queue_cmd(tcw_pkg::OP_READ, 0, 0, CELLS);
        queue_cmd(tcw_pkg::OP_READ, 8'hFF, 8'hFF, 11'h7FF);
        queue_cmd(tcw_pkg::OP_NONE, 8'hFF, 8'hFF, 11'h7FF);
        queue_cmd(tcw_pkg::OP_PRINT, 8'h7F, 8'h5A, 0);
        queue_cmd(tcw_pkg::OP_READ, 0, 0, COLUMNS);
        queue_cmd(tcw_pkg::OP_CLEAR, 8'hFF, 8'hFF, 11'h7FF);
        queue_cmd(tcw_pkg::OP_READ, 0, 0, 0);

        while (cmd_backlog.size() < 1970) begin
            sel = $urandom_range(99);
            if (sel < 70) begin
                n = ($urandom_range(7) == 0) ? $urandom_range(70, 100) : $urandom_range(0, 40);
                for (k = 0; k < n; k++) begin
                    pick = $urandom_range(99);
                    if (pick < 6)       queue_cmd(tcw_pkg::OP_PRINT, tcw_pkg::CH_BS,
                                                  $urandom_range(255), 0);
                    else if (pick < 10) queue_cmd(tcw_pkg::OP_PRINT, tcw_pkg::CH_TAB,
                                                  $urandom_range(255), 0);
                    else if (pick < 12) queue_cmd(tcw_pkg::OP_PRINT, tcw_pkg::CH_CR,
                                                  $urandom_range(255), 0);
                    else if (pick < 20) queue_cmd(tcw_pkg::OP_READ, $urandom_range(255),
                                                  $urandom_range(255), $urandom_range(479));
                    else if (pick < 60) queue_cmd(tcw_pkg::OP_PRINT,
                                                  $urandom_range(8'h20, 8'h7E),
                                                  $urandom_range(255), $urandom_range(2047));
                    else queue_cmd(tcw_pkg::OP_PRINT, $urandom_range(255), $urandom_range(255),
                                   $urandom_range(2047));
                end
                pick = $urandom_range(9);
                if (pick < 6) queue_cmd(tcw_pkg::OP_PRINT, tcw_pkg::CH_CR,
                                        $urandom_range(255), 0);
                if (pick < 9) queue_cmd(tcw_pkg::OP_PRINT, tcw_pkg::CH_LF,
                                        $urandom_range(255), 0);
            end else if (sel < 85) begin
                n = $urandom_range(1, 6);
                for (k = 0; k < n; k++)
                    queue_cmd(tcw_pkg::OP_READ, $urandom_range(255), $urandom_range(255),
                              $urandom_range(1) ? $urandom_range(2047) : $urandom_range(479));
            end else if (sel < 88) begin
                queue_cmd(tcw_pkg::OP_CLEAR, $urandom_range(255), $urandom_range(255),
                          $urandom_range(2047));
            end else if (sel < 91) begin
                queue_cmd(tcw_pkg::OP_NONE, $urandom_range(255), $urandom_range(255),
                          $urandom_range(2047));
            end else begin
                n = $urandom_range(1, 12);
                for (k = 0; k < n; k++)
                    queue_cmd(tcw_pkg::OP_PRINT,
                              $urandom_range(1) ? tcw_pkg::CH_BS : tcw_pkg::CH_TAB,
                              $urandom_range(255), $urandom_range(2047));
            end
        end
        total_cmds = cmd_backlog.size();

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (cmd_backlog.size() != 0 || i_valid || expected_views.size() != 0)
            @(negedge i_clk);
        // let a stray scroll or clear sweep finish before closing
        repeat (2100) @(posedge i_clk);

        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
